// ===== hw/rtl/gemm_pkg.sv =====
package gemm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_BITS_DEF = 16;
  localparam int COORD_W       = 3;
  localparam int VALUE_W       = 16;
  localparam int PROD_W        = 40;
  localparam int DIM_W         = 4;
  localparam int MODE_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 4;

  // request codes
  localparam logic [1:0] REQ_LEFT    = 2'd0;
  localparam logic [1:0] REQ_RIGHT   = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // operand layouts
  localparam logic [MODE_W-1:0] MODE_PLAIN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT_T  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT_T = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MULT_MODE = 2'd3;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [COORD_W-1:0]        elem_row;
    logic [COORD_W-1:0]        elem_col;
    logic signed [VALUE_W-1:0] elem_value;
  } in_req_t;

  typedef struct packed {
    logic [COORD_W-1:0]       out_row;
    logic [COORD_W-1:0]       out_col;
    logic signed [PROD_W-1:0] product;
    logic                     last;
  } out_res_t;

  // control that travels with each multiply-accumulate step
  typedef struct packed {
    logic               first;
    logic               dot_end;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } step_tag_t;

  // last index of a dimension: zero acts as one, oversize acts as the limit
  function automatic logic [DIM_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > lim) begin
      r = lim - 1'b1;
    end else begin
      r = v - 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/gemm_mem.sv =====
module gemm_mem
  import gemm_pkg::*;
#(
  parameter int ADDR_W = 6,
  parameter int WIDTH  = ELEM_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       waddr,
  input  logic signed [WIDTH-1:0] wdata,
  input  logic                    re,
  input  logic [ADDR_W-1:0]       raddr,
  output logic signed [WIDTH-1:0] rdata
);

  logic signed [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/gemm_seq.sv =====
module gemm_seq
  import gemm_pkg::*;
#(
  parameter int IDX_W = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 adv,
  input  logic [IDX_W-1:0]     m_last,
  input  logic [IDX_W-1:0]     k_last,
  input  logic [IDX_W-1:0]     n_last,
  input  logic [MODE_W-1:0]    mode,
  output logic                 active,
  output step_tag_t            tag,
  output logic [2*IDX_W-1:0]   a_addr,
  output logic [2*IDX_W-1:0]   b_addr
);

  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] p;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      i      <= '0;
      j      <= '0;
      p      <= '0;
    end else if (start) begin
      active <= 1'b1;
      i      <= '0;
      j      <= '0;
      p      <= '0;
    end else if (active && adv) begin
      if (p == k_last) begin
        p <= '0;
        if (j == n_last) begin
          j <= '0;
          if (i == m_last) begin
            active <= 1'b0;
          end else begin
            i <= i + 1'b1;
          end
        end else begin
          j <= j + 1'b1;
        end
      end else begin
        p <= p + 1'b1;
      end
    end
  end

  always_comb begin
    tag.first   = (p == '0);
    tag.dot_end = (p == k_last);
    tag.last    = (p == k_last) && (i == m_last) && (j == n_last);
    tag.row     = COORD_W'(i);
    tag.col     = COORD_W'(j);
    a_addr      = (mode == MODE_LEFT_T)  ? {p, i} : {i, p};
    b_addr      = (mode == MODE_RIGHT_T) ? {j, p} : {p, j};
  end

`ifndef SYNTH
  a_seq_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    active && adv && tag.last |=> !active)
    else $error("sequencer kept running after the final step");

  a_seq_starts_clean: assert property (@(posedge clk) disable iff (rst)
    $rose(active) |-> tag.first && i == '0 && j == '0)
    else $error("sequence did not start at the first element");
`endif

endmodule

// ===== hw/rtl/gemm_mac.sv =====
module gemm_mac
  import gemm_pkg::*;
#(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        step_valid,
  input  step_tag_t                   step_tag,
  input  logic signed [ELEM_BITS-1:0] a,
  input  logic signed [ELEM_BITS-1:0] b,
  output logic                        res_valid,
  output out_res_t                    res
);

  logic                          v2;
  step_tag_t                     t2;
  logic signed [2*ELEM_BITS-1:0] prod;
  logic signed [PROD_W-1:0]      prod_ext;
  logic signed [PROD_W-1:0]      acc;
  logic signed [PROD_W-1:0]      acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2   <= step_tag;
      prod <= a * b;
    end
  end

  assign prod_ext = PROD_W'(prod);
  assign acc_next = (t2.first ? '0 : acc) + prod_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv && v2) begin
      acc <= acc_next;
    end
  end

  // result register: load a finished sum or drop the one just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v2 && t2.dot_end;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2 && t2.dot_end) begin
      res.out_row <= t2.row;
      res.out_col <= t2.col;
      res.product <= acc_next;
      res.last    <= t2.last;
    end
  end

`ifndef SYNTH
  a_mac_result_loads: assert property (@(posedge clk) disable iff (rst)
    adv && v2 && t2.dot_end |=> res_valid)
    else $error("finished dot product did not reach the result register");

  a_mac_frozen_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v2) && $stable(acc))
    else $error("pipeline moved while frozen");
`endif

endmodule

// ===== hw/rtl/matrix_multiply_transpose_modes.sv =====
// Load request: accepted one per cycle while no compute is active; written to the store
// at the accepting edge if its coordinates are in range. Compute request: further
// requests are held until its last step is issued; each step passes the store reads,
// product and result registers, one multiply-accumulate per cycle through the single read
// port of each store. A stalled result freezes the whole multiply-accumulate pipeline.
// Reset (rst, synchronous): dimensions 8/8/8, mode plain, pipeline empty; stores undefined.
module matrix_multiply_transpose_modes
  import gemm_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_res_t              out_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int               IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int               ADDR_W  = 2 * IDX_W;
  localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(MAX_DIM);

  logic [DIM_W-1:0]  out_rows;
  logic [DIM_W-1:0]  inner_len;
  logic [DIM_W-1:0]  out_cols;
  logic [MODE_W-1:0] mult_mode;

  logic                        in_accept;
  logic                        coord_ok;
  logic [ADDR_W-1:0]           waddr;
  logic signed [ELEM_BITS-1:0] wdata;
  logic                        left_we;
  logic                        right_we;
  logic                        start;
  logic                        adv;

  logic                        active;
  step_tag_t                   tag0;
  logic [ADDR_W-1:0]           a_addr;
  logic [ADDR_W-1:0]           b_addr;
  logic [DIM_W-1:0]            m_last;
  logic [DIM_W-1:0]            k_last;
  logic [DIM_W-1:0]            n_last;

  logic                        v1;
  step_tag_t                   tag1;
  logic signed [ELEM_BITS-1:0] a_data;
  logic signed [ELEM_BITS-1:0] b_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_rows  <= DIM_W'(8);
      inner_len <= DIM_W'(8);
      out_cols  <= DIM_W'(8);
      mult_mode <= MODE_PLAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUT_ROWS:  out_rows  <= cfg_data;
        REG_INNER_LEN: inner_len <= cfg_data;
        REG_OUT_COLS:  out_cols  <= cfg_data;
        REG_MULT_MODE: mult_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_last = dim_last(out_rows, DIM_LIM);
  assign k_last = dim_last(inner_len, DIM_LIM);
  assign n_last = dim_last(out_cols, DIM_LIM);

  // hold new requests while a product is being stepped through
  assign in_stall  = active;
  assign in_accept = in_valid && !in_stall;
  assign adv       = !out_valid || !out_stall;

  assign coord_ok = ({1'b0, in_req.elem_row} < DIM_LIM) &&
                    ({1'b0, in_req.elem_col} < DIM_LIM);
  assign waddr    = {in_req.elem_row[IDX_W-1:0], in_req.elem_col[IDX_W-1:0]};
  assign wdata    = ELEM_BITS'(in_req.elem_value);
  assign left_we  = in_accept && coord_ok && (in_req.req_type == REQ_LEFT);
  assign right_we = in_accept && coord_ok && (in_req.req_type == REQ_RIGHT);
  assign start    = in_accept && (in_req.req_type == REQ_COMPUTE);

  gemm_seq #(
    .IDX_W (IDX_W)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .adv    (adv),
    .m_last (m_last[IDX_W-1:0]),
    .k_last (k_last[IDX_W-1:0]),
    .n_last (n_last[IDX_W-1:0]),
    .mode   (mult_mode),
    .active (active),
    .tag    (tag0),
    .a_addr (a_addr),
    .b_addr (b_addr)
  );

  gemm_mem #(
    .ADDR_W (ADDR_W),
    .WIDTH  (ELEM_BITS)
  ) u_left (
    .clk   (clk),
    .we    (left_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv && active),
    .raddr (a_addr),
    .rdata (a_data)
  );

  gemm_mem #(
    .ADDR_W (ADDR_W),
    .WIDTH  (ELEM_BITS)
  ) u_right (
    .clk   (clk),
    .we    (right_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv && active),
    .raddr (b_addr),
    .rdata (b_data)
  );

  // step control is registered alongside the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1 <= tag0;
    end
  end

  gemm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .step_valid (v1),
    .step_tag   (tag1),
    .a          (a_data),
    .b          (b_data),
    .res_valid  (out_valid),
    .res        (out_res)
  );

`ifndef SYNTH
  a_top_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_req.req_type == REQ_COMPUTE |=> in_stall)
    else $error("compute request did not block further requests");
`endif

endmodule
